@@ hdl/ddd_pkg.sv @@
// ----------------------------------------------------------------------------
// ddd_pkg
// Shared types, constants and calendar helpers for the date difference block.
// ----------------------------------------------------------------------------
package ddd_pkg;

  localparam int unsigned DAY_W   = 6;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned COUNT_W = 22;

  localparam logic [YEAR_W-1:0] MAX_YEAR = 12'd4095;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_MIN   = 6'd1;
  localparam logic [DAY_W-1:0]   DAY_MAX   = 6'd31;

  // Reciprocal constants: x/25 = (x*1311)>>15 for x < 4681,
  // x/100 = (x*1311)>>17 for x < 4681.
  localparam logic [10:0] RECIP = 11'd1311;
  localparam int unsigned SH25  = 15;
  localparam int unsigned SH100 = 17;

  localparam logic [8:0] DAYS_PER_YEAR = 9'd365;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // capture the input word
    logic sel_second;  // year step works on the second date
    logic yr_a;        // year step, first half
    logic yr_b;        // year step, second half
    logic sum_a;       // day of year and whole-year span
    logic commit;      // final sum into the output register
  } ddd_cmd_t;

  // Days in the months before the given month (non-leap)
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

@@ hdl/date_difference_in_days.sv @@
// ----------------------------------------------------------------------------
// date_difference_in_days
// Day count between two Gregorian dates.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one word of two dates (day, month, year each);
//   the result channel returns one word per input: the signed day count from
//   the first date to the second and a bad_input flag (count forced to 0).
//   Both channels use valid/stall; a word moves when valid is high and stall
//   is low.
//   The result shows on out_valid once the sum is written to the output register.
//   One word is handled at a time: the controller runs the shared year unit
//   twice (first and second half for each date), then a day-of-year step and a
//   sum step, and takes no new word until the sum is written.
//   The output register decouples the sides: a new word is taken while the
//   previous result waits. If the receiver stalls, the result holds and the
//   controller waits in its final step until the register frees up.
//   Reset (rst_n low, synchronous) returns the controller to idle and
//   drops any pending result.
// ----------------------------------------------------------------------------
module date_difference_in_days (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ddd_pkg::DAY_W-1:0]           in_first_day,
  input  logic [ddd_pkg::MONTH_W-1:0]         in_first_month,
  input  logic [ddd_pkg::YEAR_W-1:0]          in_first_year,
  input  logic [ddd_pkg::DAY_W-1:0]           in_second_day,
  input  logic [ddd_pkg::MONTH_W-1:0]         in_second_month,
  input  logic [ddd_pkg::YEAR_W-1:0]          in_second_year,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ddd_pkg::COUNT_W-1:0]  out_day_count,
  output logic                                out_bad_input
);
  import ddd_pkg::*;

  ddd_cmd_t cmd;

  ddd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  ddd_dpath u_dpath (
    .clk             (clk),
    .cmd             (cmd),
    .in_first_day    (in_first_day),
    .in_first_month  (in_first_month),
    .in_first_year   (in_first_year),
    .in_second_day   (in_second_day),
    .in_second_month (in_second_month),
    .in_second_year  (in_second_year),
    .out_day_count   (out_day_count),
    .out_bad_input   (out_bad_input)
  );

endmodule

@@ hdl/ddd_ctrl.sv @@
// ----------------------------------------------------------------------------
// ddd_ctrl
// Sequencer for the date difference block: steps the datapath through the
// two year computations, the day-of-year step and the final sum.
// ----------------------------------------------------------------------------
module ddd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output ddd_pkg::ddd_cmd_t cmd
);
  import ddd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YR1_A,
    ST_YR1_B,
    ST_YR2_A,
    ST_YR2_B,
    ST_SUM_A,
    ST_SUM_B
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   commit;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  // write the result once the output register is free or being drained
  assign commit    = (state_r == ST_SUM_B) && (!out_valid_r || !out_stall);

  always_comb begin
    cmd            = '0;
    cmd.load       = (state_r == ST_IDLE) && in_valid;
    cmd.sel_second = (state_r == ST_YR2_A) || (state_r == ST_YR2_B);
    cmd.yr_a       = (state_r == ST_YR1_A) || (state_r == ST_YR2_A);
    cmd.yr_b       = (state_r == ST_YR1_B) || (state_r == ST_YR2_B);
    cmd.sum_a      = (state_r == ST_SUM_A);
    cmd.commit     = commit;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_YR1_A;
      ST_YR1_A: state_nxt = ST_YR1_B;
      ST_YR1_B: state_nxt = ST_YR2_A;
      ST_YR2_A: state_nxt = ST_YR2_B;
      ST_YR2_B: state_nxt = ST_SUM_A;
      ST_SUM_A: state_nxt = ST_SUM_B;
      ST_SUM_B: if (commit) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hdl/ddd_dpath.sv @@
// ----------------------------------------------------------------------------
// ddd_dpath
// Datapath: input word registers, a shared year unit (leap years below a
// year and the leap flag), day-of-year logic and the output register.
// ----------------------------------------------------------------------------
module ddd_dpath (
  input  logic                          clk,
  input  ddd_pkg::ddd_cmd_t             cmd,
  input  logic [ddd_pkg::DAY_W-1:0]     in_first_day,
  input  logic [ddd_pkg::MONTH_W-1:0]   in_first_month,
  input  logic [ddd_pkg::YEAR_W-1:0]    in_first_year,
  input  logic [ddd_pkg::DAY_W-1:0]     in_second_day,
  input  logic [ddd_pkg::MONTH_W-1:0]   in_second_month,
  input  logic [ddd_pkg::YEAR_W-1:0]    in_second_year,
  output logic signed [ddd_pkg::COUNT_W-1:0] out_day_count,
  output logic                          out_bad_input
);
  import ddd_pkg::*;

  logic [DAY_W-1:0]   d1_r, d2_r;
  logic [MONTH_W-1:0] m1_r, m2_r;
  logic [YEAR_W-1:0]  y1_r, y2_r;

  // year unit
  logic [YEAR_W-1:0]  ysel;
  logic [YEAR_W-1:0]  yb_r;
  logic [YEAR_W:0]    y_plus3;
  logic [10:0]        c4_r, c4_nxt;
  logic [22:0]        q25_prod;
  logic [7:0]         q25_r, q25_nxt;
  logic [10:0]        c4_p24, c4_p99;
  logic [21:0]        c100_prod, c400_prod;
  logic [5:0]         c100;
  logic [3:0]         c400;
  logic [12:0]        q25_back;
  logic [10:0]        lb;
  logic               leap;
  logic [10:0]        lb1_r, lb2_r;
  logic               leap1_r, leap2_r;

  // day of year and span
  logic [9:0]         doy1, doy2;
  logic [9:0]         doy1_r, doy2_r;
  logic [YEAR_W-1:0]  span;
  logic [20:0]        span365_r;
  logic [22:0]        total;
  logic               bad;

  logic [COUNT_W-1:0] count_r;
  logic               bad_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      d1_r <= in_first_day;
      m1_r <= in_first_month;
      y1_r <= in_first_year;
      d2_r <= in_second_day;
      m2_r <= in_second_month;
      y2_r <= in_second_year;
    end
  end

  // first half: ceil(y/4) and floor(y/25)
  assign ysel     = cmd.sel_second ? y2_r : y1_r;
  assign y_plus3  = {1'b0, ysel} + 13'd3;
  assign c4_nxt   = y_plus3[12:2];
  assign q25_prod = {11'b0, ysel} * {12'b0, RECIP};
  assign q25_nxt  = q25_prod[SH25 +: 8];

  always_ff @(posedge clk) begin
    if (cmd.yr_a) begin
      yb_r  <= ysel;
      c4_r  <= c4_nxt;
      q25_r <= q25_nxt;
    end
  end

  // second half: ceil(y/100) = ceil(c4/25), ceil(y/400) = ceil(c4/100)
  assign c4_p24    = c4_r + 11'd24;
  assign c4_p99    = c4_r + 11'd99;
  assign c100_prod = {11'b0, c4_p24} * {11'b0, RECIP};
  assign c400_prod = {11'b0, c4_p99} * {11'b0, RECIP};
  assign c100      = c100_prod[SH25 +: 6];
  assign c400      = c400_prod[SH100 +: 4];
  assign lb        = c4_r - {5'b0, c100} + {7'b0, c400};
  assign q25_back  = {5'b0, q25_r} * 13'd25;
  // leap: divisible by 4, and not by 25 unless also by 16
  assign leap      = (yb_r[1:0] == 2'b00) &&
                     ((q25_back != {1'b0, yb_r}) || (yb_r[3:0] == 4'b0000));

  always_ff @(posedge clk) begin
    if (cmd.yr_b) begin
      if (cmd.sel_second) begin
        lb2_r   <= lb;
        leap2_r <= leap;
      end else begin
        lb1_r   <= lb;
        leap1_r <= leap;
      end
    end
  end

  assign doy1 = {4'b0, d1_r} + {1'b0, days_before(m1_r)} +
                {9'b0, (leap1_r && (m1_r > MONTH_FEB))};
  assign doy2 = {4'b0, d2_r} + {1'b0, days_before(m2_r)} +
                {9'b0, (leap2_r && (m2_r > MONTH_FEB))};
  assign span = y2_r - y1_r;

  always_ff @(posedge clk) begin
    if (cmd.sum_a) begin
      doy1_r    <= doy1;
      doy2_r    <= doy2;
      span365_r <= {9'b0, span} * {12'b0, DAYS_PER_YEAR};
    end
  end

  // modular sum; the true value always fits in the count width
  assign total = {13'b0, doy2_r} - {13'b0, doy1_r} + {2'b0, span365_r} +
                 {12'b0, lb2_r} - {12'b0, lb1_r};

  assign bad = (d1_r < DAY_MIN) || (d1_r > DAY_MAX) ||
               (d2_r < DAY_MIN) || (d2_r > DAY_MAX) ||
               (m1_r < MONTH_JAN) || (m1_r > MONTH_DEC) ||
               (m2_r < MONTH_JAN) || (m2_r > MONTH_DEC) ||
               (y1_r > MAX_YEAR) || (y2_r > MAX_YEAR) ||
               (y1_r > y2_r) || ((y1_r == y2_r) && (m1_r > m2_r));

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      count_r <= bad ? '0 : total[COUNT_W-1:0];
      bad_r   <= bad;
    end
  end

  assign out_day_count = $signed(count_r);
  assign out_bad_input = bad_r;

endmodule

@@ hdl/ddd_checker.sv @@
// ----------------------------------------------------------------------------
// ddd_checker
// Port-level checks for the date difference block, bound to the top level.
// ----------------------------------------------------------------------------
module ddd_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [ddd_pkg::COUNT_W-1:0]  out_day_count,
  input logic                                out_bad_input
);
  import ddd_pkg::*;

  // a rejected word always reports a zero count
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_input |-> out_day_count == '0)
    else $error("bad_input result with nonzero day_count");

  // negative counts never go below -30
  a_neg_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_day_count[COUNT_W-1] |-> out_day_count >= -22'sd30)
    else $error("day_count below -30");

  // one word at a time: the word after an accepted one is stalled
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on consecutive cycles");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_day_count) &&
                               $stable(out_bad_input))
    else $error("stalled result changed");

endmodule

bind date_difference_in_days ddd_checker u_ddd_checker (.*);
